FILE: rtl/assert_macros.svh
// Assertion shorthands used by the checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, quiet while reset is asserted.
`define OCT_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked assertion that also holds through reset.
`define OCT_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/oct_pkg.sv
`default_nettype none

package oct_pkg;

  localparam int CMD_W    = 3;
  localparam int IDX_IN_W = 4;
  localparam int ID_W     = 32;
  localparam int STATUS_W = 3;
  localparam int CNT_W    = 5;
  localparam int TOTAL_W  = 32;
  localparam int ENT_W    = 3;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_POST     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DISPATCH = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SENDFAIL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RESPONSE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ABANDON  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_RELEASE  = 3'd5;

  // Entry states
  localparam logic [ENT_W-1:0] ENT_FREE      = 3'd0;
  localparam logic [ENT_W-1:0] ENT_POSTED    = 3'd1;
  localparam logic [ENT_W-1:0] ENT_SENT      = 3'd2;
  localparam logic [ENT_W-1:0] ENT_DONE      = 3'd3;
  localparam logic [ENT_W-1:0] ENT_ABANDONED = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STS_NOTHING   = 3'd1;
  localparam logic [STATUS_W-1:0] STS_UNMATCHED = 3'd2;
  localparam logic [STATUS_W-1:0] STS_IGNORED   = 3'd3;
  localparam logic [STATUS_W-1:0] STS_WRONG     = 3'd4;

  localparam logic [CNT_W-1:0] CEIL_RESET = 5'd8;

  // Slots in the queue between front and back
  localparam int QSLOTS = 2;
  localparam int QPTR_W = 1;

  // Classified command as it travels from front to back
  typedef struct packed {
    logic [CMD_W-1:0]    op;
    logic                known;
    logic                idx_ok;
    logic [IDX_IN_W-1:0] idx;
    logic [ID_W-1:0]     sess;
    logic [ID_W-1:0]     seq;
  } oct_item_t;

endpackage

`default_nettype wire

FILE: rtl/oct_ifs.sv
`default_nettype none

interface oct_cmd_if;
  import oct_pkg::*;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [IDX_IN_W-1:0] entry_index;
  logic [ID_W-1:0]     owner_id;
  logic [ID_W-1:0]     seq_num;

  modport source (output valid, cmd, entry_index, owner_id, seq_num, input ready);
  modport sink (input valid, cmd, entry_index, owner_id, seq_num, output ready);
endinterface

interface oct_rsp_if;
  import oct_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [IDX_IN_W-1:0] result_index;
  logic [CNT_W-1:0]    in_flight_now;
  logic [CNT_W-1:0]    peak_in_flight;
  logic [TOTAL_W-1:0]  total_dispatched;

  modport source (output valid, status, result_index, in_flight_now, peak_in_flight,
                  total_dispatched, input ready);
  modport sink (input valid, status, result_index, in_flight_now, peak_in_flight,
                total_dispatched, output ready);
endinterface

interface oct_cfg_if;
  import oct_pkg::*;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/oct_front.sv
`default_nettype none

module oct_front #(
  parameter int QUEUE_DEPTH = 16
) (
  oct_cmd_if.sink            in_bus,
  output logic               push_valid,
  input  logic               push_ready,
  output oct_pkg::oct_item_t push_item
);
  import oct_pkg::*;

  assign in_bus.ready = push_ready;
  assign push_valid   = in_bus.valid;

  always_comb begin
    push_item.op     = in_bus.cmd;
    push_item.known  = (in_bus.cmd <= CMD_RELEASE);
    push_item.idx_ok = (32'(in_bus.entry_index) < 32'(QUEUE_DEPTH));
    push_item.idx    = in_bus.entry_index;
    push_item.sess   = in_bus.owner_id;
    push_item.seq    = in_bus.seq_num;
  end

endmodule

`default_nettype wire

FILE: rtl/oct_queue.sv
`default_nettype none

module oct_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  oct_pkg::oct_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output oct_pkg::oct_item_t pop_item
);
  import oct_pkg::*;

  localparam int FILL_W = $clog2(QSLOTS + 1);

  oct_item_t          slot_r [QSLOTS];
  logic [QPTR_W-1:0]  wr_ptr_r;
  logic [QPTR_W-1:0]  rd_ptr_r;
  logic [FILL_W-1:0]  fill_r;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (fill_r != FILL_W'(QSLOTS));
  assign pop_valid  = (fill_r != '0);
  assign pop_item   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop) fill_r <= fill_r + 1'b1;
      else if (do_pop && !do_push) fill_r <= fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_item;
  end

endmodule

`default_nettype wire

FILE: rtl/oct_back.sv
`default_nettype none

module oct_back #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  oct_pkg::oct_item_t pop_item,
  oct_cfg_if.sink            cfg_bus,
  oct_rsp_if.source          out_bus
);
  import oct_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);

  localparam logic S_LOAD = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                 state_r;

  // Entry table: state has reset, owner and sequence are written on post
  logic [ENT_W-1:0]     ent_st_r  [QUEUE_DEPTH];
  logic [ID_W-1:0]      owner_r   [QUEUE_DEPTH];
  logic [ID_W-1:0]      seqid_r   [QUEUE_DEPTH];

  logic [CNT_W-1:0]     ceil_r;
  logic [CNT_W-1:0]     cnt_r,  cnt_nxt;
  logic [CNT_W-1:0]     peak_r, peak_nxt;
  logic [TOTAL_W-1:0]   total_r, total_nxt;

  // Snapshot taken in the load cycle
  oct_item_t            item_r;
  logic [QUEUE_DEPTH-1:0] sent_hit_r,  sent_hit;
  logic [QUEUE_DEPTH-1:0] aband_hit_r, aband_hit;
  logic [QUEUE_DEPTH-1:0] posted_r,    posted;
  logic [ENT_W-1:0]     cur_st_r;

  logic                 out_valid_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic [IDX_IN_W-1:0]  out_index_r;

  logic                 load;
  logic                 commit;
  logic [IDX_W-1:0]     tidx;
  logic [STATUS_W-1:0]  sts;
  logic [IDX_IN_W-1:0]  rix;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_idx;
  logic [ENT_W-1:0]     wr_val;
  logic                 post_wr;
  logic [IDX_W-1:0]     first_posted;
  logic [IDX_W-1:0]     first_sent;
  logic [IDX_W-1:0]     first_aband;

  function automatic logic [IDX_W-1:0] lowest(input logic [QUEUE_DEPTH-1:0] v);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (v[i]) r = IDX_W'(i);
    end
    return r;
  endfunction

  assign pop_ready = (state_r == S_LOAD);
  assign load      = pop_valid && pop_ready;
  assign commit    = (state_r == S_EXEC) && (!out_valid_r || out_bus.ready);
  assign tidx      = IDX_W'(pop_item.idx);
  assign cfg_bus.ready = 1'b1;

  // Compare every entry against the incoming ids in the load cycle
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      sent_hit[i]  = (ent_st_r[i] == ENT_SENT) && (owner_r[i] == pop_item.sess) &&
                     (seqid_r[i] == pop_item.seq);
      aband_hit[i] = (ent_st_r[i] == ENT_ABANDONED) && (owner_r[i] == pop_item.sess) &&
                     (seqid_r[i] == pop_item.seq);
      posted[i]    = (ent_st_r[i] == ENT_POSTED);
    end
  end

  assign first_posted = lowest(posted_r);
  assign first_sent   = lowest(sent_hit_r);
  assign first_aband  = lowest(aband_hit_r);

  always_comb begin
    sts       = STS_OK;
    rix       = '0;
    wr_en     = 1'b0;
    wr_idx    = IDX_W'(item_r.idx);
    wr_val    = ENT_FREE;
    post_wr   = 1'b0;
    cnt_nxt   = cnt_r;
    peak_nxt  = peak_r;
    total_nxt = total_r;
    if (!item_r.known) begin
      sts = STS_IGNORED;
    end else begin
      unique case (item_r.op)
        CMD_POST: begin
          if (item_r.idx_ok && cur_st_r == ENT_FREE) begin
            wr_en   = 1'b1;
            wr_val  = ENT_POSTED;
            post_wr = 1'b1;
          end else begin
            sts = STS_WRONG;
          end
        end
        CMD_DISPATCH: begin
          if (cnt_r < ceil_r && |posted_r) begin
            wr_en     = 1'b1;
            wr_idx    = first_posted;
            wr_val    = ENT_SENT;
            cnt_nxt   = cnt_r + 1'b1;
            peak_nxt  = (cnt_r + 1'b1 > peak_r) ? cnt_r + 1'b1 : peak_r;
            total_nxt = total_r + 1'b1;
            rix       = IDX_IN_W'(first_posted);
          end else begin
            sts = STS_NOTHING;
          end
        end
        CMD_SENDFAIL: begin
          if (item_r.idx_ok && cur_st_r == ENT_SENT) begin
            wr_en  = 1'b1;
            wr_val = ENT_POSTED;
            if (cnt_r != '0) cnt_nxt = cnt_r - 1'b1;
          end else begin
            sts = STS_WRONG;
          end
        end
        CMD_RESPONSE: begin
          if (cnt_r == '0) begin
            sts = STS_IGNORED;
          end else begin
            cnt_nxt = cnt_r - 1'b1;
            priority if (|sent_hit_r) begin
              wr_en  = 1'b1;
              wr_idx = first_sent;
              wr_val = ENT_DONE;
              rix    = IDX_IN_W'(first_sent);
            end else if (|aband_hit_r) begin
              wr_en  = 1'b1;
              wr_idx = first_aband;
              wr_val = ENT_FREE;
              rix    = IDX_IN_W'(first_aband);
            end else begin
              sts = STS_UNMATCHED;
            end
          end
        end
        CMD_ABANDON: begin
          if (item_r.idx_ok && cur_st_r == ENT_SENT) begin
            wr_en  = 1'b1;
            wr_val = ENT_ABANDONED;
          end else if (item_r.idx_ok && cur_st_r == ENT_POSTED) begin
            wr_en  = 1'b1;
            wr_val = ENT_FREE;
          end else begin
            sts = STS_WRONG;
          end
        end
        CMD_RELEASE: begin
          if (item_r.idx_ok && cur_st_r == ENT_DONE) begin
            wr_en  = 1'b1;
            wr_val = ENT_FREE;
          end else begin
            sts = STS_WRONG;
          end
        end
        default: sts = STS_IGNORED;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      ceil_r      <= CEIL_RESET;
      cnt_r       <= '0;
      peak_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < QUEUE_DEPTH; i++) ent_st_r[i] <= ENT_FREE;
    end else begin
      if (cfg_bus.valid) ceil_r <= cfg_bus.data;
      unique case (state_r)
        S_LOAD: if (load) state_r <= S_EXEC;
        S_EXEC: if (commit) state_r <= S_LOAD;
        default: state_r <= S_LOAD;
      endcase
      if (commit) begin
        cnt_r       <= cnt_nxt;
        peak_r      <= peak_nxt;
        total_r     <= total_nxt;
        out_valid_r <= 1'b1;
        if (wr_en) ent_st_r[wr_idx] <= wr_val;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk) begin
    if (load) begin
      item_r      <= pop_item;
      sent_hit_r  <= sent_hit;
      aband_hit_r <= aband_hit;
      posted_r    <= posted;
      cur_st_r    <= ent_st_r[tidx];
    end
    if (commit) begin
      out_status_r <= sts;
      out_index_r  <= rix;
    end
    if (commit && post_wr) begin
      owner_r[wr_idx] <= item_r.sess;
      seqid_r[wr_idx] <= item_r.seq;
    end
  end

  assign out_bus.valid            = out_valid_r;
  assign out_bus.status           = out_status_r;
  assign out_bus.result_index     = out_index_r;
  assign out_bus.in_flight_now    = cnt_r;
  assign out_bus.peak_in_flight   = peak_r;
  assign out_bus.total_dispatched = total_r;

endmodule

`default_nettype wire

FILE: rtl/outstanding_command_tracker.sv
// Channel  Dir  Carries                                              Handshake
// in_bus   in   cmd, entry_index, owner_id, seq_num                  valid/ready
// out_bus  out  status, result_index, in_flight_now, peak_in_flight,  valid/ready
//               total_dispatched
// cfg_bus  in   data (inflight_ceiling)                              valid/ready
//
// In the back end each command first compares all entries against the command's
// ids and snapshots the table, then updates the table and loads the result
// register. A two-slot queue sits between the front and the back end.
// Reset (rst_n low, synchronous) frees all entries and clears the counters. A
// stalled result holds the back end in its update cycle; the queue keeps
// taking commands until it is full. cfg_bus is always ready.
`default_nettype none

module outstanding_command_tracker #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  oct_cmd_if.sink   in_bus,
  oct_rsp_if.source out_bus,
  oct_cfg_if.sink   cfg_bus
);
  import oct_pkg::*;

  logic      push_valid;
  logic      push_ready;
  oct_item_t push_item;
  logic      pop_valid;
  logic      pop_ready;
  oct_item_t pop_item;

  oct_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
    .in_bus     (in_bus),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  oct_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  oct_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .cfg_bus   (cfg_bus),
    .out_bus   (out_bus)
  );

endmodule

`default_nettype wire

FILE: rtl/oct_checker.sv
`default_nettype none
`include "assert_macros.svh"

module oct_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [oct_pkg::STATUS_W-1:0] out_status,
  input logic [oct_pkg::IDX_IN_W-1:0] out_index,
  input logic [oct_pkg::CNT_W-1:0]    out_now,
  input logic [oct_pkg::CNT_W-1:0]    out_peak
);
  import oct_pkg::*;

  `OCT_ASSERT_RST(a_rst_clears_out, clk, !rst_n |=> !out_valid, "result valid after reset")

  `OCT_ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result lost")

  `OCT_ASSERT_CLK(a_fail_no_index, clk, rst_n,
                  out_valid && out_status != STS_OK |-> out_index == '0, "index on failure")

  `OCT_ASSERT_CLK(a_peak_bound, clk, rst_n, out_valid |-> out_now <= out_peak, "count above peak")

endmodule

bind outstanding_command_tracker oct_checker u_oct_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_bus.valid),
  .out_ready  (out_bus.ready),
  .out_status (out_bus.status),
  .out_index  (out_bus.result_index),
  .out_now    (out_bus.in_flight_now),
  .out_peak   (out_bus.peak_in_flight)
);

`default_nettype wire
